>>> rtl/core/assert_macros.svh
// Assertion helpers used by the core RTL (pts_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset.
`define PTS_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

>>> rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types, codes and sizes shared by the page timestamp merge scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int MAX_STREAMS = 16;
	localparam int STREAM_W    = 4;
	// the stream field reaches at most 2**STREAM_W streams
	localparam int NUM_CELLS   = (MAX_STREAMS < (1 << STREAM_W)) ? MAX_STREAMS
	                                                             : (1 << STREAM_W);
	localparam int CUR_W       = STREAM_W + 1;
	localparam int COUNT_W     = 5;
	localparam int KIND_W      = 3;
	localparam int CMD_W       = 2;
	localparam int TIME_W      = 64;
	localparam int CNT_W       = $clog2(NUM_CELLS + 1);

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] CELL_LIMIT  = COUNT_W'(NUM_CELLS);
	localparam logic [CNT_W-1:0]   SCAN_LAST   = CNT_W'(NUM_CELLS);
	localparam logic [TIME_W-1:0]  ALL_ONES    = '1;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_START     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HDR_OK    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HDR_FAIL  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PAGE_DONE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PAGE_FAIL = 3'd4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_FETCH    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FORWARD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISHED = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [STREAM_W-1:0] stream;
		logic [TIME_W-1:0]   granule;
	} in_t;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [STREAM_W-1:0] target_stream;
		logic [TIME_W-1:0]   round_time;
	} out_t;

	typedef enum logic [1:0] {
		PH_REFILL  = 2'd0,
		PH_FORWARD = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPLY
	} ctrl_state_t;

	typedef enum logic [2:0] {
		CELL_NOP,
		CELL_START,
		CELL_HDR_OK,
		CELL_HDR_FAIL,
		CELL_PAGE_DONE,
		CELL_PAGE_FAIL
	} cell_op_t;

	// state update broadcast to all cells on an accepted event
	typedef struct packed {
		cell_op_t            op;
		logic [STREAM_W-1:0] stream;
		logic [COUNT_W-1:0]  count;
		logic [TIME_W-1:0]   granule;
	} cell_upd_t;

	// search context held steady during a scan
	typedef struct packed {
		logic [CUR_W-1:0]  cursor;
		logic [TIME_W-1:0] rmin;
	} scan_ctx_t;

	// partial search results handed from cell to cell
	typedef struct packed {
		logic                ref_cur_found;
		logic [STREAM_W-1:0] ref_cur_idx;
		logic                ref0_found;
		logic [STREAM_W-1:0] ref0_idx;
		logic                fwd_found;
		logic [STREAM_W-1:0] fwd_idx;
		logic                min_found;
		logic [STREAM_W-1:0] min_idx;
		logic [TIME_W-1:0]   min_time;
	} scan_t;

	localparam scan_t SCAN_INIT = '{
		ref_cur_found: 1'b0, ref_cur_idx: '0,
		ref0_found:    1'b0, ref0_idx:    '0,
		fwd_found:     1'b0, fwd_idx:     '0,
		min_found:     1'b0, min_idx:     '0,
		min_time:      ALL_ONES
	};

endpackage

>>> rtl/core/pts_cell.sv
// ----------------------------------------------------------------------------
// pts_cell
// One stream slot: live/needs-header flags and head time, plus one step of
// the search wave that runs down the chain.
// ----------------------------------------------------------------------------
module pts_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pts_pkg::STREAM_W-1:0]  idx,
	input  pts_pkg::cell_upd_t            upd,
	input  pts_pkg::scan_ctx_t            ctx,
	input  pts_pkg::scan_t                scan_in,
	output pts_pkg::scan_t                scan_out
);

	logic                         live_q;
	logic                         needs_q;
	logic [pts_pkg::TIME_W-1:0]   head_q;
	pts_pkg::scan_t               scan_nx;
	pts_pkg::scan_t               scan_q;
	logic                         hit;
	logic                         pend;
	logic                         want_hdr;
	logic                         from_cur;

	assign hit = (upd.stream == idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= 1'b0;
			needs_q <= 1'b1;
		end else begin
			unique case (upd.op)
				pts_pkg::CELL_START: begin
					live_q  <= ({1'b0, idx} < upd.count);
					needs_q <= 1'b1;
				end
				pts_pkg::CELL_HDR_OK: begin
					if (hit) needs_q <= 1'b0;
				end
				pts_pkg::CELL_HDR_FAIL: begin
					if (hit) live_q <= 1'b0;
				end
				pts_pkg::CELL_PAGE_DONE: begin
					if (hit) needs_q <= 1'b1;
				end
				pts_pkg::CELL_PAGE_FAIL: begin
					if (hit) begin
						needs_q <= 1'b1;
						live_q  <= 1'b0;
					end
				end
				pts_pkg::CELL_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (upd.op == pts_pkg::CELL_HDR_OK && hit) head_q <= upd.granule;
	end

	assign pend     = live_q && !needs_q;
	assign want_hdr = live_q && needs_q;
	assign from_cur = ({1'b0, idx} >= ctx.cursor);

	// for the header and forward searches the first match wins, so an earlier cell's find is never overwritten
	always_comb begin
		scan_nx = scan_in;
		if (want_hdr && from_cur && !scan_in.ref_cur_found) begin
			scan_nx.ref_cur_found = 1'b1;
			scan_nx.ref_cur_idx   = idx;
		end
		if (want_hdr && !scan_in.ref0_found) begin
			scan_nx.ref0_found = 1'b1;
			scan_nx.ref0_idx   = idx;
		end
		if (pend && from_cur && head_q == ctx.rmin && !scan_in.fwd_found) begin
			scan_nx.fwd_found = 1'b1;
			scan_nx.fwd_idx   = idx;
		end
		// strict compare: all-ones heads never count, ties keep the lower index
		if (pend && head_q < scan_in.min_time) begin
			scan_nx.min_found = 1'b1;
			scan_nx.min_idx   = idx;
			scan_nx.min_time  = head_q;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_nx;
	end

	assign scan_out = scan_q;

endmodule

>>> rtl/core/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Event decode, scan sequencing and command registers of the merge scheduler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pts_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  pts_pkg::in_t                  item,
	output logic                          busy,
	output logic                          result_valid,
	output pts_pkg::out_t                 result,
	input  logic                          cfg_wen,
	input  logic [pts_pkg::COUNT_W-1:0]   cfg_data,
	output pts_pkg::cell_upd_t            upd,
	output pts_pkg::scan_ctx_t            ctx,
	input  pts_pkg::scan_t                scan_res
);

	pts_pkg::ctrl_state_t                 state_q;
	pts_pkg::ctrl_state_t                 state_nx;
	pts_pkg::phase_t                      phase_q;
	pts_pkg::phase_t                      phase_nx;
	pts_pkg::phase_t                      mode_q;
	logic [pts_pkg::STREAM_W-1:0]         cursor_q;
	logic [pts_pkg::STREAM_W-1:0]         cursor_nx;
	logic [pts_pkg::TIME_W-1:0]           rmin_q;
	logic [pts_pkg::TIME_W-1:0]           rmin_nx;
	logic [pts_pkg::CUR_W-1:0]            scan_cur_q;
	logic [pts_pkg::CNT_W-1:0]            cnt_q;
	logic [pts_pkg::COUNT_W-1:0]          count_q;
	logic [pts_pkg::COUNT_W-1:0]          eff_count;
	logic                                 accept;
	logic                                 is_start;
	logic                                 ev_ok;
	logic                                 scan_end;

	assign accept   = start && !busy;
	assign is_start = (item.kind == pts_pkg::KIND_START);
	assign scan_end = (state_q == pts_pkg::ST_SCAN) && (cnt_q == pts_pkg::SCAN_LAST);

	// events that do not match the pending command are dropped
	always_comb begin
		ev_ok = 1'b0;
		if (phase_q != pts_pkg::PH_DONE && item.stream == cursor_q) begin
			if (phase_q == pts_pkg::PH_REFILL)
				ev_ok = (item.kind == pts_pkg::KIND_HDR_OK) ||
				        (item.kind == pts_pkg::KIND_HDR_FAIL);
			else
				ev_ok = (item.kind == pts_pkg::KIND_PAGE_DONE) ||
				        (item.kind == pts_pkg::KIND_PAGE_FAIL);
		end
	end

	assign eff_count = (count_q > pts_pkg::CELL_LIMIT) ? pts_pkg::CELL_LIMIT : count_q;

	always_comb begin
		upd.op      = pts_pkg::CELL_NOP;
		upd.stream  = item.stream;
		upd.count   = eff_count;
		upd.granule = item.granule;
		if (accept) begin
			if (is_start) begin
				upd.op = pts_pkg::CELL_START;
			end else if (ev_ok) begin
				priority case (item.kind)
					pts_pkg::KIND_HDR_OK:    upd.op = pts_pkg::CELL_HDR_OK;
					pts_pkg::KIND_HDR_FAIL:  upd.op = pts_pkg::CELL_HDR_FAIL;
					pts_pkg::KIND_PAGE_DONE: upd.op = pts_pkg::CELL_PAGE_DONE;
					pts_pkg::KIND_PAGE_FAIL: upd.op = pts_pkg::CELL_PAGE_FAIL;
					default:                 upd.op = pts_pkg::CELL_NOP;
				endcase
			end
		end
	end

	assign ctx.cursor = scan_cur_q;
	assign ctx.rmin   = rmin_q;

	// next command from the finished search wave
	always_comb begin
		phase_nx  = phase_q;
		cursor_nx = cursor_q;
		rmin_nx   = rmin_q;
		priority if (mode_q == pts_pkg::PH_FORWARD && scan_res.fwd_found) begin
			phase_nx  = pts_pkg::PH_FORWARD;
			cursor_nx = scan_res.fwd_idx;
		end else if (mode_q == pts_pkg::PH_REFILL && scan_res.ref_cur_found) begin
			phase_nx  = pts_pkg::PH_REFILL;
			cursor_nx = scan_res.ref_cur_idx;
			rmin_nx   = pts_pkg::ALL_ONES;
		end else if (mode_q == pts_pkg::PH_FORWARD && scan_res.ref0_found) begin
			phase_nx  = pts_pkg::PH_REFILL;
			cursor_nx = scan_res.ref0_idx;
			rmin_nx   = pts_pkg::ALL_ONES;
		end else if (!scan_res.min_found) begin
			phase_nx  = pts_pkg::PH_DONE;
			cursor_nx = '0;
			rmin_nx   = pts_pkg::ALL_ONES;
		end else begin
			phase_nx  = pts_pkg::PH_FORWARD;
			cursor_nx = scan_res.min_idx;
			rmin_nx   = scan_res.min_time;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pts_pkg::ST_IDLE, pts_pkg::ST_REPLY: begin
				if (accept)
					state_nx = (is_start || ev_ok) ? pts_pkg::ST_SCAN : pts_pkg::ST_REPLY;
				else
					state_nx = pts_pkg::ST_IDLE;
			end
			pts_pkg::ST_SCAN: begin
				if (scan_end) state_nx = pts_pkg::ST_REPLY;
			end
			default: state_nx = pts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = (state_q == pts_pkg::ST_SCAN);
		result_valid = (state_q == pts_pkg::ST_REPLY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pts_pkg::ST_IDLE;
			phase_q    <= pts_pkg::PH_DONE;
			mode_q     <= pts_pkg::PH_REFILL;
			cursor_q   <= '0;
			rmin_q     <= pts_pkg::ALL_ONES;
			scan_cur_q <= '0;
			cnt_q      <= '0;
			count_q    <= pts_pkg::COUNT_RESET;
		end else begin
			state_q <= state_nx;
			if (cfg_wen) count_q <= cfg_data;
			if (accept) begin
				cnt_q <= '0;
				if (is_start) begin
					mode_q     <= pts_pkg::PH_REFILL;
					scan_cur_q <= '0;
				end else begin
					mode_q     <= phase_q;
					scan_cur_q <= pts_pkg::CUR_W'({1'b0, cursor_q}) + pts_pkg::CUR_W'(1);
				end
			end else if (state_q == pts_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + pts_pkg::CNT_W'(1);
			end
			if (scan_end) begin
				phase_q  <= phase_nx;
				cursor_q <= cursor_nx;
				rmin_q   <= rmin_nx;
			end
		end
	end

	always_comb begin
		unique case (phase_q)
			pts_pkg::PH_REFILL: begin
				result.command       = pts_pkg::CMD_FETCH;
				result.target_stream = cursor_q;
			end
			pts_pkg::PH_FORWARD: begin
				result.command       = pts_pkg::CMD_FORWARD;
				result.target_stream = cursor_q;
			end
			default: begin
				result.command       = pts_pkg::CMD_FINISHED;
				result.target_stream = '0;
			end
		endcase
		result.round_time = rmin_q;
	end

	`PTS_ASSERT(a_start_scans, clk, arst_n, start && !busy && item.kind == pts_pkg::KIND_START |=> busy, "start did not launch a scan")
	`PTS_ASSERT(a_fin_target, clk, arst_n, result_valid && result.command == pts_pkg::CMD_FINISHED |-> result.target_stream == '0, "finished with nonzero stream")
	`PTS_ASSERT(a_fwd_time, clk, arst_n, result_valid && result.command == pts_pkg::CMD_FORWARD |-> result.round_time != pts_pkg::ALL_ONES, "forward without a round minimum")
	`PTS_ASSERT(a_fetch_time, clk, arst_n, result_valid && result.command == pts_pkg::CMD_FETCH |-> result.round_time == pts_pkg::ALL_ONES, "fetch with a round minimum set")
	`PTS_ASSERT_RST(a_reset_quiet, clk, !arst_n |=> !result_valid && !busy, "activity during reset")

endmodule

>>> rtl/core/page_timestamp_merge_scheduler.sv
// ----------------------------------------------------------------------------
// page_timestamp_merge_scheduler
// Interleaves pages of several streams in granule order: one command per
// data mover event, searched by a wave through a chain of stream cells.
// ----------------------------------------------------------------------------
//  channel   ports                      transfer when
//  event     start, busy, item          start && !busy
//  command   result_valid, result       result_valid (one cycle, no stall)
//  config    cfg_wen, cfg_data          cfg_wen
//
// A start or matching event runs a search wave through the NUM_CELLS cells,
// one cell per cycle while busy; the command shows in the cycle after busy.
// A dropped event skips the scan and goes straight to its command.
// The next event may be taken in the cycle its predecessor's command shows.
// Reset leaves the block finished, no stream live, stream count 1.
// ----------------------------------------------------------------------------
module page_timestamp_merge_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pts_pkg::in_t                  item,
	output logic                          result_valid,
	output pts_pkg::out_t                 result,
	input  logic                          cfg_wen,
	input  logic [pts_pkg::COUNT_W-1:0]   cfg_data
);

	pts_pkg::cell_upd_t   upd;
	pts_pkg::scan_ctx_t   ctx;
	pts_pkg::scan_t       chain [pts_pkg::NUM_CELLS+1];

	assign chain[0] = pts_pkg::SCAN_INIT;

	pts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_data     (cfg_data),
		.upd          (upd),
		.ctx          (ctx),
		.scan_res     (chain[pts_pkg::NUM_CELLS])
	);

	for (genvar i = 0; i < pts_pkg::NUM_CELLS; i++) begin : g_cell
		pts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (pts_pkg::STREAM_W'(i)),
			.upd      (upd),
			.ctx      (ctx),
			.scan_in  (chain[i]),
			.scan_out (chain[i+1])
		);
	end

endmodule

>>> tb/page_timestamp_merge_scheduler_tb.sv
// ----------------------------------------------------------------------------
// page_timestamp_merge_scheduler_tb
// Drives data mover events into the merge scheduler and checks every command
// against a local model of the round logic (refill, forward by minimum
// granule, finished). Directed cases first, then random rounds over several
// stream counts with random gaps between events.
// ----------------------------------------------------------------------------
module page_timestamp_merge_scheduler_tb;

	localparam logic [pts_pkg::KIND_W-1:0] KIND_BAD   = 3'd7;
	localparam int                         STREAM_CAP =
		(pts_pkg::MAX_STREAMS < (1 << pts_pkg::STREAM_W)) ? pts_pkg::MAX_STREAMS
		                                                  : (1 << pts_pkg::STREAM_W);

	typedef struct packed {
		logic [pts_pkg::COUNT_W-1:0]                        count;
		logic [pts_pkg::COUNT_W-1:0]                        active;
		logic [pts_pkg::NUM_CELLS-1:0]                      live;
		logic [pts_pkg::NUM_CELLS-1:0]                      need_hdr;
		logic [pts_pkg::NUM_CELLS-1:0][pts_pkg::TIME_W-1:0] head;
		logic [pts_pkg::TIME_W-1:0]                         rmin;
		pts_pkg::phase_t                                    ph;
		logic [pts_pkg::CUR_W-1:0]                          cur;
	} sched_state_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	pts_pkg::in_t                item = '0;
	logic                        result_valid;
	pts_pkg::out_t               result;
	logic                        cfg_wen = 1'b0;
	logic [pts_pkg::COUNT_W-1:0] cfg_data = '0;

	sched_state_t  plan_state;   // advanced as events are queued, steers the generator
	sched_state_t  track_state;  // advanced as events are accepted by the block
	pts_pkg::in_t  pending_events[$];
	pts_pkg::out_t due_commands[$];
	int            mismatches = 0;
	int            hold_off = 0;
	bit            idle_on = 1'b0;
	logic [pts_pkg::TIME_W-1:0] gbase = '0;

	page_timestamp_merge_scheduler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// move to the next command, scanning from the cursor
	function automatic void settle_round(inout sched_state_t s);
		int          pass, i;
		bit          settled;
		logic [pts_pkg::TIME_W-1:0] m;
		settled = 1'b0;
		for (pass = 0; pass < 4 && !settled; pass++) begin
			if (s.ph == pts_pkg::PH_REFILL) begin
				for (i = s.cur; i < s.active && !settled; i++)
					if (s.live[i] && s.need_hdr[i]) begin
						s.cur = pts_pkg::CUR_W'(i);
						settled = 1'b1;
					end
				if (!settled) begin
					m = pts_pkg::ALL_ONES;
					for (i = 0; i < s.active; i++)
						if (s.live[i] && !s.need_hdr[i] && s.head[i] < m)
							m = s.head[i];
					s.rmin = m;
					s.cur = '0;
					if (m == pts_pkg::ALL_ONES) begin
						s.ph = pts_pkg::PH_DONE;
						settled = 1'b1;
					end else begin
						s.ph = pts_pkg::PH_FORWARD;
					end
				end
			end
			if (!settled && s.ph == pts_pkg::PH_FORWARD) begin
				for (i = s.cur; i < s.active && !settled; i++)
					if (s.live[i] && !s.need_hdr[i] && s.head[i] == s.rmin) begin
						s.cur = pts_pkg::CUR_W'(i);
						settled = 1'b1;
					end
				if (!settled) begin
					s.ph = pts_pkg::PH_REFILL;
					s.cur = '0;
					s.rmin = pts_pkg::ALL_ONES;
				end
			end else if (!settled && s.ph == pts_pkg::PH_DONE) begin
				settled = 1'b1;
			end
		end
		if (!settled) begin
			s.ph = pts_pkg::PH_DONE;
			s.cur = '0;
			s.rmin = pts_pkg::ALL_ONES;
		end
	endfunction

	// apply one event and return the command the block must answer with
	function automatic pts_pkg::out_t next_command(inout sched_state_t s,
	                                               input pts_pkg::in_t ev);
		pts_pkg::out_t r;
		int            i;
		if (ev.kind == pts_pkg::KIND_START) begin
			s.active = (s.count > STREAM_CAP) ? pts_pkg::COUNT_W'(STREAM_CAP) : s.count;
			for (i = 0; i < pts_pkg::NUM_CELLS; i++)
				s.live[i] = (i < s.active);
			s.need_hdr = '1;
			s.rmin = pts_pkg::ALL_ONES;
			s.ph = pts_pkg::PH_REFILL;
			s.cur = '0;
			settle_round(s);
		end else if (s.ph != pts_pkg::PH_DONE && pts_pkg::CUR_W'(ev.stream) == s.cur
		             && pts_pkg::COUNT_W'(ev.stream) < s.active) begin
			if (s.ph == pts_pkg::PH_REFILL && (ev.kind == pts_pkg::KIND_HDR_OK
			                                   || ev.kind == pts_pkg::KIND_HDR_FAIL)) begin
				if (ev.kind == pts_pkg::KIND_HDR_OK) begin
					s.head[ev.stream] = ev.granule;
					s.need_hdr[ev.stream] = 1'b0;
				end else begin
					s.live[ev.stream] = 1'b0;
				end
				s.cur = pts_pkg::CUR_W'(ev.stream) + pts_pkg::CUR_W'(1);
				settle_round(s);
			end else if (s.ph == pts_pkg::PH_FORWARD
			             && (ev.kind == pts_pkg::KIND_PAGE_DONE
			                 || ev.kind == pts_pkg::KIND_PAGE_FAIL)) begin
				s.need_hdr[ev.stream] = 1'b1;
				if (ev.kind == pts_pkg::KIND_PAGE_FAIL)
					s.live[ev.stream] = 1'b0;
				s.cur = pts_pkg::CUR_W'(ev.stream) + pts_pkg::CUR_W'(1);
				settle_round(s);
			end
		end
		case (s.ph)
			pts_pkg::PH_REFILL:  r.command = pts_pkg::CMD_FETCH;
			pts_pkg::PH_FORWARD: r.command = pts_pkg::CMD_FORWARD;
			default:             r.command = pts_pkg::CMD_FINISHED;
		endcase
		r.target_stream = (s.ph == pts_pkg::PH_DONE) ? '0 : s.cur[pts_pkg::STREAM_W-1:0];
		r.round_time = s.rmin;
		return r;
	endfunction

	task automatic report(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic queue_event(input logic [pts_pkg::KIND_W-1:0] k,
	                           input logic [pts_pkg::STREAM_W-1:0] s,
	                           input logic [pts_pkg::TIME_W-1:0] g);
		pts_pkg::in_t  ev;
		pts_pkg::out_t unused;
		ev.kind = k;
		ev.stream = s;
		ev.granule = g;
		pending_events.push_back(ev);
		unused = next_command(plan_state, ev);
	endtask

	// sampled on the falling edge so driver updates have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || start || due_commands.size() != 0);
	endtask

	task automatic configure_when_idle(input logic [pts_pkg::COUNT_W-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		plan_state.count = value;
		track_state.count = value;
	endtask

	// driver: holds an event while busy, then, when idle_on is set, inserts a random gap
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				due_commands.push_back(next_command(track_state, item));
				if (!idle_on)
					hold_off = 0;
				else begin
					hold_off = $urandom_range(0, 99);
					hold_off = (hold_off < 55) ? 0 :
					           (hold_off < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				end
			end
			if (!(start && busy)) begin
				if (hold_off > 0) begin
					hold_off--;
					start <= 1'b0;
				end else if (pending_events.size() != 0) begin
					start <= 1'b1;
					item <= pending_events.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed command must match the oldest expectation
	always @(posedge clk) begin
		pts_pkg::out_t want;
		if (arst_n && result_valid) begin
			if (due_commands.size() == 0) begin
				report($sformatf("unexpected command %0d stream %0d", result.command,
				                 result.target_stream));
			end else begin
				want = due_commands.pop_front();
				if (result.command !== want.command)
					report($sformatf("command %0d, want %0d", result.command, want.command));
				if (result.target_stream !== want.target_stream)
					report($sformatf("target_stream %0d, want %0d", result.target_stream,
					                 want.target_stream));
				if (result.round_time !== want.round_time)
					report($sformatf("round_time %h, want %h", result.round_time,
					                 want.round_time));
			end
		end
	end

	initial begin
		int                           p, taken, r, pick;
		logic [pts_pkg::COUNT_W-1:0]  cnt;
		logic [pts_pkg::STREAM_W-1:0] st;
		logic [pts_pkg::TIME_W-1:0]   g;

		track_state.count = pts_pkg::COUNT_RESET;
		track_state.active = '0;
		track_state.live = '0;
		track_state.need_hdr = '1;
		track_state.head = '0;
		track_state.rmin = pts_pkg::ALL_ONES;
		track_state.ph = pts_pkg::PH_DONE;
		track_state.cur = '0;
		plan_state = track_state;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: stream count 1 after reset
		queue_event(pts_pkg::KIND_HDR_OK, 4'd0, 64'd5);          // while finished
		queue_event(pts_pkg::KIND_START, 4'd9, '0);              // stream field ignored
		queue_event(pts_pkg::KIND_HDR_OK, 4'd0, '0);
		queue_event(pts_pkg::KIND_HDR_OK, 4'd0, 64'd3);          // header while forwarding
		queue_event(pts_pkg::KIND_PAGE_DONE, 4'd0, '0);
		queue_event(pts_pkg::KIND_HDR_OK, 4'd0, pts_pkg::ALL_ONES); // only all-ones head
		queue_event(pts_pkg::KIND_START, 4'd0, '0);
		queue_event(KIND_BAD, 4'd0, '0);
		queue_event(pts_pkg::KIND_HDR_FAIL, 4'd0, '0);
		// no streams at all
		configure_when_idle(5'd0);
		queue_event(pts_pkg::KIND_START, 4'd0, '0);
		queue_event(pts_pkg::KIND_PAGE_DONE, 4'd0, '0);
		// three streams: mismatches, tie, failures
		configure_when_idle(5'd3);
		queue_event(pts_pkg::KIND_START, 4'd15, pts_pkg::ALL_ONES);
		queue_event(pts_pkg::KIND_HDR_OK, 4'd2, 64'd1);          // wrong stream
		queue_event(pts_pkg::KIND_PAGE_DONE, 4'd0, '0);          // page event while refilling
		queue_event(pts_pkg::KIND_HDR_OK, 4'd0, 64'd7);
		queue_event(pts_pkg::KIND_HDR_FAIL, 4'd1, '0);
		queue_event(pts_pkg::KIND_HDR_OK, 4'd2, 64'd7);
		queue_event(pts_pkg::KIND_PAGE_FAIL, 4'd0, '0);
		queue_event(pts_pkg::KIND_PAGE_DONE, 4'd2, '0);
		queue_event(pts_pkg::KIND_HDR_OK, 4'd2, pts_pkg::ALL_ONES - pts_pkg::TIME_W'(1));
		queue_event(pts_pkg::KIND_PAGE_DONE, 4'd2, '0);
		queue_event(pts_pkg::KIND_HDR_FAIL, 4'd2, '0);
		queue_event(pts_pkg::KIND_HDR_OK, 4'd15, 64'd2);

		for (p = 0; p < 8; p++) begin
			case (p)
				0:       cnt = 5'd16;
				1:       cnt = 5'd1;
				2:       cnt = 5'd31;
				3:       cnt = 5'd2;
				4:       cnt = 5'd17;
				default: cnt = pts_pkg::COUNT_W'($urandom_range(1, 16));
			endcase
			configure_when_idle(cnt);
			idle_on = ($urandom_range(0, 3) != 0);
			taken = 0;
			while (taken < 85) begin
				r = $urandom_range(0, 99);
				st = pts_pkg::STREAM_W'($urandom);
				g = {$urandom, $urandom};
				if (plan_state.ph == pts_pkg::PH_DONE || r < 2) begin
					queue_event(pts_pkg::KIND_START, st, g);
					taken++;
				end else if (r < 9) begin
					queue_event(pts_pkg::KIND_W'($urandom_range(0, 7)), st, g);
				end else if (plan_state.ph == pts_pkg::PH_REFILL) begin
					// mostly clustered granules so rounds see ties
					pick = $urandom_range(0, 19);
					if (pick == 1)
						g = pts_pkg::ALL_ONES;
					else if (pick == 2)
						g = pts_pkg::ALL_ONES - pts_pkg::TIME_W'(1);
					else if (pick != 0) begin
						if (pick == 3)
							gbase = {$urandom, $urandom};
						gbase = gbase + pts_pkg::TIME_W'($urandom_range(0, 2));
						g = gbase + pts_pkg::TIME_W'($urandom_range(0, 3));
					end
					queue_event((r < 16) ? pts_pkg::KIND_HDR_FAIL : pts_pkg::KIND_HDR_OK,
					            plan_state.cur[pts_pkg::STREAM_W-1:0], g);
					taken++;
				end else begin
					queue_event((r < 15) ? pts_pkg::KIND_PAGE_FAIL : pts_pkg::KIND_PAGE_DONE,
					            plan_state.cur[pts_pkg::STREAM_W-1:0], g);
					taken++;
				end
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("** page_timestamp_merge_scheduler: PASSED **");
		else
			$display("** page_timestamp_merge_scheduler: FAILED **");
		$finish;
	end

	initial begin
		#5000000;
		$display("** page_timestamp_merge_scheduler: FAILED **");
		$finish;
	end

endmodule
